>>> design/met_pkg.sv
// Shared types, register indexes and helpers for the Mandelbrot escape-time pixel block.
// Depends on nothing; the top level imports it.
package met_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int GRAY_BITS      = 8;
    localparam int RING_STAGES    = 3;
    localparam int LIMIT_SHIFT    = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_X_MIN    = 3'd0,
        REG_Y_MIN    = 3'd1,
        REG_X_STEP   = 3'd2,
        REG_Y_STEP   = 3'd3,
        REG_MAX_ITER = 3'd4
    } cfg_reg_t;

    typedef logic [1:0] ring_idx_t;

    localparam ring_idx_t RING_LAST = ring_idx_t'(RING_STAGES - 1);
    localparam ring_idx_t RING_FULL = ring_idx_t'(RING_STAGES);

    function automatic ring_idx_t ring_next(input ring_idx_t i);
        ring_next = (i == RING_LAST) ? '0 : i + ring_idx_t'(1);
    endfunction

endpackage

>>> design/mandelbrot_escape_time_pixel_top.sv
// Top level of the Mandelbrot escape-time pixel block: coordinate mapping, the shared
// three-stage iteration ring, in-order retirement and the gray-level divider pipeline.
// Depends on met_pkg.
//
// Usage: a request (pixel_col, pixel_row) is taken at a rising edge where start is high
// and busy is low. Up to three pixels are in flight at once; they share one iteration
// loop of three register stages (products, sums and escape test, shift and saturate),
// so the loop as a whole performs one iteration per cycle when all three slots hold a pixel.
// A request is taken only when a free slot passes the loop entry, so it may have to wait.
// Three requests may be taken back to back; busy then stays high until the oldest pixel
// retires and its slot comes back round to the loop entry.
// Results leave in request order. Each is shown on iter_count, inside_set and gray_level
// for one cycle with done high; the receiver cannot stall the block. Between the accepting edge
// and the edge that presents the result lie the three mapping stages, the loop passes, a
// capture register and eight divider stages; a finished pixel may also wait behind an older one.
// Configuration must be written by the user through cfg_we, cfg_index and cfg_data only while
// no request is in flight; the block itself does not enforce this. Reset clears all valid bits
// and loads the default view and a limit of 1000.
module mandelbrot_escape_time_pixel_top #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 28,
    parameter int INDEX_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [met_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [INDEX_BITS-1:0]               pixel_col,
    input  logic [INDEX_BITS-1:0]               pixel_row,
    output logic                                done,
    output logic [COUNT_BITS-1:0]               iter_count,
    output logic                                inside_set,
    output logic [met_pkg::GRAY_BITS-1:0]       gray_level
);
    import met_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PB = 2 * COORD_BITS;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int MP = INDEX_BITS + COORD_BITS - 1;
    localparam int MW = INDEX_BITS + COORD_BITS + 1;
    localparam int NW = COUNT_BITS + GRAY_BITS;

    localparam logic signed [CB-1:0] COORD_ONE  = CB'(1) << FRAC_BITS;
    localparam logic signed [CB-1:0] COORD_MAX  = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] COORD_MIN  = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-2:0]        STEP_RESET = (CB-1)'(2147484);
    localparam logic [COUNT_BITS-1:0] ITER_RESET = COUNT_BITS'(1000);
    localparam logic [PB:0]          LIMIT = (PB+1)'(1) << (2 * FRAC_BITS + LIMIT_SHIFT);

    typedef struct packed {
        logic                   done;
        logic signed [CB-1:0]   cx;
        logic signed [CB-1:0]   cy;
        logic [COUNT_BITS-1:0]  count;
        logic signed [CB-1:0]   x;
        logic signed [CB-1:0]   y;
    } thread_t;

    typedef struct packed {
        logic                   done;
        logic signed [CB-1:0]   cx;
        logic signed [CB-1:0]   cy;
        logic [COUNT_BITS-1:0]  count;
        logic signed [PB-1:0]   xx;
        logic signed [PB-1:0]   yy;
        logic signed [PB-1:0]   xy;
    } prod_t;

    typedef struct packed {
        logic                   done;
        logic signed [CB-1:0]   cx;
        logic signed [CB-1:0]   cy;
        logic [COUNT_BITS-1:0]  count;
        logic                   escape;
        logic signed [PW-1:0]   xt;
        logic signed [PW-1:0]   yt;
    } sum_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic                   in_set;
        logic [NW-1:0]          rem;
        logic [GRAY_BITS-1:0]   quo;
    } div_t;

    function automatic logic signed [CB-1:0] sat_map(input logic signed [MW-1:0] v);
        logic [MW-CB:0] hi;
        hi = v[MW-1:CB-1];
        if (hi == '0 || hi == {(MW-CB+1){1'b1}})
            sat_map = v[CB-1:0];
        else
            sat_map = v[MW-1] ? COORD_MIN : COORD_MAX;
    endfunction

    function automatic logic signed [CB-1:0] sat_iter(input logic signed [PW-1:0] v);
        logic [PW-CB:0] hi;
        hi = v[PW-1:CB-1];
        if (hi == '0 || hi == {(PW-CB+1){1'b1}})
            sat_iter = v[CB-1:0];
        else
            sat_iter = v[PW-1] ? COORD_MIN : COORD_MAX;
    endfunction

    logic signed [CB-1:0]   x_min_reg;
    logic signed [CB-1:0]   y_min_reg;
    logic [CB-2:0]          x_step_reg;
    logic [CB-2:0]          y_step_reg;
    logic [COUNT_BITS-1:0]  max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg    <= -COORD_ONE;
            y_min_reg    <= -COORD_ONE;
            x_step_reg   <= STEP_RESET;
            y_step_reg   <= STEP_RESET;
            max_iter_reg <= ITER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_MIN:    x_min_reg    <= cfg_data;
                REG_Y_MIN:    y_min_reg    <= cfg_data;
                REG_X_STEP:   x_step_reg   <= cfg_data[CB-2:0];
                REG_Y_STEP:   y_step_reg   <= cfg_data[CB-2:0];
                REG_MAX_ITER: max_iter_reg <= cfg_data[COUNT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Slot bookkeeping: slots fill and retire in ring order, so the ring acts as a FIFO.
    ring_idx_t phase_reg, phase_next;
    ring_idx_t head_reg, head_next;
    ring_idx_t tail_reg, tail_next;
    ring_idx_t fill_reg, fill_next;
    logic      accept;
    logic      retire;

    logic                   p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [INDEX_BITS-1:0]  p1_col_reg, p1_row_reg;
    logic [MP-1:0]          p2_px_reg, p2_py_reg;
    logic signed [CB-1:0]   p3_cx_reg, p3_cy_reg;

    logic      st1_valid_reg, st2_valid_reg, st3_valid_reg;
    logic      st1_valid_next;
    prod_t     st1_reg, st1_next;
    sum_t      st2_reg, st2_next;
    thread_t   st3_reg, st3_next;

    logic signed [CB-1:0]   x_in, y_in, cx_in, cy_in;
    logic [COUNT_BITS-1:0]  count_in;
    logic                   done_in;
    logic [PB:0]            mag_sum;

    assign busy   = !(phase_reg == tail_reg && fill_reg != RING_FULL);
    assign accept = start && !busy;
    assign retire = st3_valid_reg && st3_reg.done && phase_reg == head_reg;

    always_comb
    begin
        phase_next = ring_next(phase_reg);
        tail_next  = accept ? ring_next(tail_reg) : tail_reg;
        head_next  = retire ? ring_next(head_reg) : head_reg;
        unique case ({accept, retire})
            2'b10:   fill_next = fill_reg + ring_idx_t'(1);
            2'b01:   fill_next = fill_reg - ring_idx_t'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            p1_valid_reg  <= accept;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_col_reg <= pixel_col;
            p1_row_reg <= pixel_row;
        end
        p2_px_reg <= p1_col_reg * x_step_reg;
        p2_py_reg <= p1_row_reg * y_step_reg;
        p3_cx_reg <= sat_map(MW'(x_min_reg) + $signed({2'b00, p2_px_reg}));
        p3_cy_reg <= sat_map(MW'(y_min_reg) + $signed({2'b00, p2_py_reg}));
    end

    // A new pixel lands in the free slot that is passing the loop entry.
    always_comb
    begin
        if (p3_valid_reg)
        begin
            x_in     = p3_cx_reg;
            y_in     = p3_cy_reg;
            cx_in    = p3_cx_reg;
            cy_in    = p3_cy_reg;
            count_in = '0;
            done_in  = 1'b0;
        end
        else
        begin
            x_in     = st3_reg.x;
            y_in     = st3_reg.y;
            cx_in    = st3_reg.cx;
            cy_in    = st3_reg.cy;
            count_in = st3_reg.count;
            done_in  = st3_reg.done;
        end
        st1_valid_next = p3_valid_reg || (st3_valid_reg && !retire);

        st1_next.done  = done_in;
        st1_next.cx    = cx_in;
        st1_next.cy    = cy_in;
        st1_next.count = count_in;
        st1_next.xx    = x_in * x_in;
        st1_next.yy    = y_in * y_in;
        st1_next.xy    = x_in * y_in;

        mag_sum         = {1'b0, st1_reg.xx} + {1'b0, st1_reg.yy};
        st2_next.done   = st1_reg.done;
        st2_next.cx     = st1_reg.cx;
        st2_next.cy     = st1_reg.cy;
        st2_next.count  = st1_reg.count;
        st2_next.escape = mag_sum > LIMIT;
        st2_next.xt     = PW'(st1_reg.xx) - PW'(st1_reg.yy) + (PW'(st1_reg.cx) <<< FRAC_BITS);
        st2_next.yt     = (PW'(st1_reg.xy) <<< 1) + (PW'(st1_reg.cy) <<< FRAC_BITS);

        st3_next.cx    = st2_reg.cx;
        st3_next.cy    = st2_reg.cy;
        st3_next.x     = sat_iter(st2_reg.xt >>> FRAC_BITS);
        st3_next.y     = sat_iter(st2_reg.yt >>> FRAC_BITS);
        st3_next.done  = st2_reg.done;
        st3_next.count = st2_reg.count;
        if (st2_valid_reg && !st2_reg.done)
        begin
            if (st2_reg.count >= max_iter_reg || st2_reg.escape)
                st3_next.done = 1'b1;
            else
                st3_next.count = st2_reg.count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg <= st1_next;
        st2_reg <= st2_next;
        st3_reg <= st3_next;
    end

    // Gray level: restoring division of 255 * count by the limit, one quotient bit a stage.
    logic  dv_valid_reg [0:GRAY_BITS];
    div_t  dv_reg       [0:GRAY_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else
            dv_valid_reg[0] <= retire;
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0].count  <= st3_reg.count;
        dv_reg[0].in_set <= st3_reg.count >= max_iter_reg;
        dv_reg[0].rem    <= (NW'(st3_reg.count) << GRAY_BITS) - NW'(st3_reg.count);
        dv_reg[0].quo    <= '0;
    end

    for (genvar k = 0; k < GRAY_BITS; k++)
    begin : g_div
        logic [NW-1:0] dvs;
        logic          take;

        assign dvs  = NW'(max_iter_reg) << (GRAY_BITS - 1 - k);
        assign take = dv_reg[k].rem >= dvs;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1].count  <= dv_reg[k].count;
            dv_reg[k+1].in_set <= dv_reg[k].in_set;
            dv_reg[k+1].rem    <= take ? dv_reg[k].rem - dvs : dv_reg[k].rem;
            dv_reg[k+1].quo    <= dv_reg[k].quo | (GRAY_BITS'(take) << (GRAY_BITS - 1 - k));
        end
    end

    assign done       = dv_valid_reg[GRAY_BITS];
    assign iter_count = dv_reg[GRAY_BITS].count;
    assign inside_set = dv_reg[GRAY_BITS].in_set;
    assign gray_level = (max_iter_reg == '0) ? '0 : dv_reg[GRAY_BITS].quo;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= RING_FULL)
        else $error("slot fill count exceeds the ring depth");

    a_land_free: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg |-> !st3_valid_reg)
        else $error("new pixel lands on an occupied slot");

    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == '0 |-> !(st1_valid_reg || st2_valid_reg || st3_valid_reg || p3_valid_reg))
        else $error("ring holds a pixel while the fill count is zero");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> iter_count <= max_iter_reg)
        else $error("iteration count exceeds the limit");

    a_inside_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && inside_set |-> iter_count == max_iter_reg)
        else $error("inside flag set below the limit");

endmodule

>>> tb/mandelbrot_escape_time_pixel_checker.sv
// Checker for the Mandelbrot escape-time pixel block: tracks register writes, predicts the
// escape count, inside flag and gray level of each request and compares them in order.
// Depends on met_pkg.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [met_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               start,
    input  logic                               busy,
    input  logic [11:0]                        pixel_col,
    input  logic [11:0]                        pixel_row,
    input  logic                               done,
    input  logic [15:0]                        iter_count,
    input  logic                               inside_set,
    input  logic [met_pkg::GRAY_BITS-1:0]      gray_level,
    output int                                 mismatches,
    output int                                 outstanding
);

    import met_pkg::*;

    localparam int FRAC = 28;
    localparam logic signed [127:0] COORD_MAX    = (128'sd1 <<< 31) - 128'sd1;
    localparam logic signed [127:0] COORD_MIN    = -(128'sd1 <<< 31);
    localparam logic signed [127:0] ESCAPE_LIMIT = 128'sd1 <<< (2 * FRAC + 2);

    typedef struct {
        logic [11:0]          col;
        logic [11:0]          row;
        logic [15:0]          count;
        logic                 in_set;
        logic [GRAY_BITS-1:0] gray;
    } escape_result_t;

    logic signed [31:0] x_min_r;
    logic signed [31:0] y_min_r;
    logic [30:0]        x_step_r;
    logic [30:0]        y_step_r;
    logic [15:0]        max_iter_r;

    escape_result_t pending_pixels[$];

    function automatic logic signed [127:0] clamp_coord(input logic signed [127:0] v);
        if (v > COORD_MAX)
        begin
            return COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            return COORD_MIN;
        end
        return v;
    endfunction

    function automatic escape_result_t escape_time(input logic [11:0] col, input logic [11:0] row);
        logic signed [127:0] base;
        logic signed [127:0] idx;
        logic signed [127:0] stp;
        logic signed [127:0] cx;
        logic signed [127:0] cy;
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic signed [127:0] xx;
        logic signed [127:0] yy;
        logic signed [127:0] xt;
        logic signed [127:0] yt;
        logic [31:0]         iters;
        escape_result_t      r;
        base = x_min_r;
        idx = col;
        stp = x_step_r;
        cx = clamp_coord(base + idx * stp);
        base = y_min_r;
        idx = row;
        stp = y_step_r;
        cy = clamp_coord(base + idx * stp);
        x = cx;
        y = cy;
        iters = 0;
        while (iters < max_iter_r)
        begin
            xx = x * x;
            yy = y * y;
            if (xx + yy > ESCAPE_LIMIT)
            begin
                break;
            end
            xt = xx - yy + (cx <<< FRAC);
            yt = ((x * y) <<< 1) + (cy <<< FRAC);
            x = clamp_coord(xt >>> FRAC);
            y = clamp_coord(yt >>> FRAC);
            iters++;
        end
        r.col = col;
        r.row = row;
        r.count = iters[15:0];
        r.in_set = (iters >= max_iter_r);
        r.gray = (max_iter_r != 0) ? GRAY_BITS'((32'd255 * iters) / max_iter_r) : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 50)
        begin
            $display("%0t checker: %s", $time, msg);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        escape_result_t want;
        if (!rst_n)
        begin
            x_min_r = -(32'sd1 <<< FRAC);
            y_min_r = -(32'sd1 <<< FRAC);
            x_step_r = 31'd2147484;
            y_step_r = 31'd2147484;
            max_iter_r = 16'd1000;
            pending_pixels.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_X_MIN:    x_min_r = cfg_data;
                    REG_Y_MIN:    y_min_r = cfg_data;
                    REG_X_STEP:   x_step_r = cfg_data[30:0];
                    REG_Y_STEP:   y_step_r = cfg_data[30:0];
                    REG_MAX_ITER: max_iter_r = cfg_data[15:0];
                    default:      ;
                endcase
            end
            if (start && !busy)
            begin
                pending_pixels.push_back(escape_time(pixel_col, pixel_row));
            end
            if (done)
            begin
                if (pending_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("result with no request waiting, count %0d",
                                              iter_count));
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (iter_count !== want.count)
                    begin
                        report_mismatch($sformatf("pixel (%0d,%0d) iter_count %0d, expected %0d",
                                                  want.col, want.row, iter_count, want.count));
                    end
                    if (inside_set !== want.in_set)
                    begin
                        report_mismatch($sformatf("pixel (%0d,%0d) inside_set %0b, expected %0b",
                                                  want.col, want.row, inside_set, want.in_set));
                    end
                    if (gray_level !== want.gray)
                    begin
                        report_mismatch($sformatf("pixel (%0d,%0d) gray_level %0d, expected %0d",
                                                  want.col, want.row, gray_level, want.gray));
                    end
                end
            end
            outstanding <= pending_pixels.size();
        end
    end

endmodule

>>> tb/mandelbrot_escape_time_pixel_top_test.sv
// Stimulus and verdict for the Mandelbrot escape-time pixel block: directed views and limits,
// then random views and pixels sent in bursts. Depends on met_pkg, the block and the checker.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_top_test;

    import met_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [31:0]                cfg_data;
    logic                       start;
    logic                       busy;
    logic [11:0]                pixel_col;
    logic [11:0]                pixel_row;
    logic                       done;
    logic [15:0]                iter_count;
    logic                       inside_set;
    logic [GRAY_BITS-1:0]       gray_level;
    int                         mismatches;
    int                         outstanding;
    int                         burst_left;

    mandelbrot_escape_time_pixel_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .done       (done),
        .iter_count (iter_count),
        .inside_set (inside_set),
        .gray_level (gray_level)
    );

    mandelbrot_escape_time_pixel_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .done        (done),
        .iter_count  (iter_count),
        .inside_set  (inside_set),
        .gray_level  (gray_level),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("mandelbrot_escape_time_pixel_top_test: done, errors");
        $finish;
    end

    task automatic program_view(input logic [31:0] xmin, input logic [31:0] ymin,
                                input logic [31:0] xs, input logic [31:0] ys,
                                input logic [31:0] limit);
        cfg_reg_t    order[5];
        logic [31:0] vals[5];
        order = '{REG_X_MIN, REG_Y_MIN, REG_X_STEP, REG_Y_STEP, REG_MAX_ITER};
        vals = '{xmin, ymin, xs, ys, limit};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= order[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic issue_request(input logic [11:0] col, input logic [11:0] row, input bit last);
        pixel_col <= col;
        pixel_row <= row;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (last || burst_left == 0)
        begin
            start <= 1'b0;
            if (!last)
            begin
                repeat ($urandom_range(1, 16)) @(posedge clk);
                burst_left = $urandom_range(0, 24);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            issue_request(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                          i == count - 1);
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_X_MIN;
        cfg_data = '0;
        start = 1'b0;
        pixel_col = '0;
        pixel_row = '0;
        burst_left = 4;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Square view from -2 to 2 on both axes.
        program_view(-32'sd536870912, -32'sd536870912, 32'd262144, 32'd262144, 32'd1000);
        issue_request(12'd0, 12'd0, 0);
        issue_request(12'd4095, 12'd4095, 0);
        issue_request(12'd4095, 12'd0, 0);
        issue_request(12'd0, 12'd4095, 0);
        issue_request(12'd1024, 12'd2048, 0);
        issue_request(12'd2048, 12'd2048, 0);
        issue_request(12'd0, 12'd2048, 0);
        issue_request(12'd3072, 12'd2048, 1);
        wait_idle();

        program_view(-32'sd536870912, -32'sd536870912, 32'd262144, 32'd262144, 32'd0);
        issue_request(12'd2048, 12'd2048, 0);
        issue_request(12'd0, 12'd0, 0);
        issue_request(12'd4095, 12'd4095, 1);
        wait_idle();

        program_view(-32'sd536870912, -32'sd536870912, 32'd262144, 32'd262144, 32'd1);
        issue_request(12'd2048, 12'd2048, 0);
        issue_request(12'd0, 12'd0, 0);
        issue_request(12'd3072, 12'd2048, 1);
        wait_idle();

        // Unit grid with the largest limit; (2,0) sits exactly on the escape radius.
        program_view(32'd0, 32'd0, 32'd268435456, 32'd268435456, 32'd65535);
        issue_request(12'd0, 12'd0, 0);
        issue_request(12'd2, 12'd0, 0);
        issue_request(12'd0, 12'd2, 0);
        issue_request(12'd1, 12'd0, 0);
        issue_request(12'd4095, 12'd4095, 1);
        wait_idle();

        // Coordinates that saturate at both ends of the signed range.
        program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd255);
        issue_request(12'd0, 12'd0, 0);
        issue_request(12'd1, 12'd0, 0);
        issue_request(12'd1, 12'd4095, 0);
        issue_request(12'd4095, 12'd1, 0);
        issue_request(12'd0, 12'd4095, 1);
        wait_idle();

        repeat (4)
        begin
            program_view(-32'($urandom_range(0, 32'd805306368)),
                         -32'($urandom_range(0, 32'd536870912)),
                         32'($urandom_range(32'd4096, 32'd262144)),
                         32'($urandom_range(32'd4096, 32'd262144)),
                         32'($urandom_range(1, 200)));
            run_random(120);
        end

        program_view($urandom, $urandom, $urandom, $urandom,
                     {16'($urandom), 16'($urandom_range(1, 100))});
        run_random(100);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("mandelbrot_escape_time_pixel_top_test: done, clean");
        end
        else
        begin
            $display("mandelbrot_escape_time_pixel_top_test: done, errors");
        end
        $finish;
    end

endmodule
